// ===== sv/lens_distortion_point_map_unit_defines.svh =====
// Assertion macros shared by the lens distortion point map RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef LENS_DISTORTION_POINT_MAP_UNIT_DEFINES_SVH
`define LENS_DISTORTION_POINT_MAP_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LDPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LDPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ldpm_pkg.sv =====
`default_nettype none
package ldpm_pkg;

  // Coordinate and register widths.
  localparam int COORD_W = 24;
  localparam int FOC_W   = 24;
  localparam int COEF_W  = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int FRAC_W  = 24;
  localparam int NUM_W   = DIFF_W + FRAC_W;
  localparam int QW      = 64;

  localparam logic signed [QW-1:0] LIM     = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [QW-1:0] ONE_Q24 = 64'sh0000_0000_0100_0000;
  localparam logic signed [QW-1:0] OUT_MAX = 64'sd8388607;
  localparam logic signed [QW-1:0] OUT_MIN = -64'sd8388608;

  localparam logic signed [COEF_W-1:0] K3_DEFAULT = 32'sd0;

  typedef enum logic [2:0] {
    REG_FOCAL_X    = 3'd0,
    REG_FOCAL_Y    = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_RADIAL_ONE = 3'd4,
    REG_RADIAL_TWO = 3'd5,
    REG_TANG_ONE   = 3'd6,
    REG_TANG_TWO   = 3'd7
  } cfg_idx_e;

  // Saturated value together with its overflow flag.
  typedef struct packed {
    logic                   sat;
    logic signed [QW-1:0]   v;
  } sres_t;

  typedef struct packed {
    logic                     clip;
    logic signed [COORD_W-1:0] row;
    logic signed [COORD_W-1:0] col;
  } res_t;

  // Saturating add, clamped to +-LIM.
  function automatic sres_t sadd(input logic signed [QW-1:0] a,
                                 input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    sres_t r;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s > $signed({LIM[QW-1], LIM})) begin
      r.sat = 1'b1;
      r.v   = LIM;
    end else if (s < -$signed({LIM[QW-1], LIM})) begin
      r.sat = 1'b1;
      r.v   = -LIM;
    end else begin
      r.sat = 1'b0;
      r.v   = s[QW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ldpm_dly.sv =====
`default_nettype none
module ldpm_dly import ldpm_pkg::*; #(
  parameter int W = QW,
  parameter int N = 1
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[N-1];

endmodule
`default_nettype wire

// ===== sv/ldpm_qmul.sv =====
`default_nettype none
// Q24 product with round half away from zero and saturation, three stages.
module ldpm_qmul import ldpm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [QW-1:0] a_i,
  input  wire logic signed [QW-1:0] b_i,
  output logic signed      [QW-1:0] p_o,
  output logic                      sat_o
);

  logic [QW-1:0] ua, ub;
  logic [QW-1:0] pll_q, plh_q, phl_q, phh_q;
  logic          neg1_q, neg2_q;
  logic [2*QW-1:0] sum_q;
  logic [QW-1:0] r;
  logic          ov;
  logic [QW-1:0] rv;
  logic signed [QW-1:0] p_q;
  logic          sat_q;

  assign ua = a_i[QW-1] ? QW'(-a_i) : QW'(a_i);
  assign ub = b_i[QW-1] ? QW'(-b_i) : QW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= a_i[QW-1] ^ b_i[QW-1];
      pll_q  <= ua[31:0]  * ub[31:0];
      plh_q  <= ua[31:0]  * ub[63:32];
      phl_q  <= ua[63:32] * ub[31:0];
      phh_q  <= ua[63:32] * ub[63:32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg2_q <= neg1_q;
      sum_q  <= {phh_q, 64'd0} + {32'd0, plh_q, 32'd0} + {32'd0, phl_q, 32'd0}
              + {64'd0, pll_q} + 128'd8388608;
    end
  end

  assign r  = sum_q[87:24];
  assign ov = (|sum_q[127:88]) || (r > QW'(LIM));
  assign rv = ov ? QW'(LIM) : r;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= neg2_q ? -signed'(rv) : signed'(rv);
      sat_q <= ov;
    end
  end

  assign p_o   = p_q;
  assign sat_o = sat_q;

endmodule
`default_nettype wire

// ===== sv/ldpm_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per stage, plus a sign stage.
// Computes round(d * 2^24 / f) with ties away from zero.
module ldpm_div import ldpm_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [DIFF_W-1:0] d_i,
  input  wire logic        [FOC_W-1:0]  f_i,
  output logic signed      [QW-1:0]     q_o
);

  logic [DIFF_W-1:0] ud;
  logic [NUM_W-1:0]  num0;
  logic [FOC_W-1:0]  rem_q [NUM_W];
  logic [NUM_W-1:0]  num_q [NUM_W];
  logic [NUM_W-1:0]  quo_q [NUM_W];
  logic              neg_q [NUM_W];
  logic signed [QW-1:0] q_q;

  assign ud   = d_i[DIFF_W-1] ? DIFF_W'(-d_i) : DIFF_W'(d_i);
  assign num0 = {ud, FRAC_W'(0)} + NUM_W'(f_i >> 1);

  for (genvar i = 0; i < NUM_W; i++) begin : g_it
    logic [FOC_W-1:0] rin;
    logic [NUM_W-1:0] nin, qin;
    logic             nneg;
    logic [FOC_W:0]   t;
    logic             ge;
    if (i == 0) begin : g_first
      assign rin  = '0;
      assign nin  = num0;
      assign qin  = '0;
      assign nneg = d_i[DIFF_W-1];
    end else begin : g_next
      assign rin  = rem_q[i-1];
      assign nin  = num_q[i-1];
      assign qin  = quo_q[i-1];
      assign nneg = neg_q[i-1];
    end
    assign t  = {rin, nin[NUM_W-1]};
    assign ge = (t >= {1'b0, f_i});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? FOC_W'(t - {1'b0, f_i}) : t[FOC_W-1:0];
        num_q[i] <= {nin[NUM_W-2:0], 1'b0};
        quo_q[i] <= {qin[NUM_W-2:0], ge};
        neg_q[i] <= nneg;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= neg_q[NUM_W-1] ? -signed'(QW'(quo_q[NUM_W-1]))
                            : signed'(QW'(quo_q[NUM_W-1]));
    end
  end

  assign q_o = q_q;

endmodule
`default_nettype wire

// ===== sv/lens_distortion_point_map_unit.sv =====
// Channel     | Dir | Handshake                     | Payload
// s_axis      | in  | s_axis_tvalid / s_axis_tready | tdata: in_col, in_row
// m_axis      | out | m_axis_tvalid / m_axis_tready | tdata: out_col, out_row; tuser: clipped
// cfg         | in  | cfg_we_i (no wait)            | cfg_idx_i, cfg_wdata_i
//
// One point enters per clock while the output buffer has room; each point passes one offset
// stage, 50 divider stages and 23 stages of multiply and add to the result register, and is
// then written into the output buffer, from which it can leave.
// The latency is set by the bit-per-stage divider and the chain of six dependent
// three-stage Q24 multipliers. rst_ni clears the valid bits, the output buffer and
// the configuration registers to their documented reset values. The pipeline moves as a
// whole and freezes only when the two-entry output buffer is full.
`default_nettype none
`include "lens_distortion_point_map_unit_defines.svh"
module lens_distortion_point_map_unit import ldpm_pkg::*; #(
  parameter logic signed [COEF_W-1:0] RADIAL_THREE_Q24 = K3_DEFAULT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: [23:0] in_col, [47:24] in_row
  input  wire logic [2*COORD_W-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata: [23:0] out_col, [47:24] out_row
  output logic [2*COORD_W-1:0]     m_axis_tdata,
  // tuser: [0] clipped
  output logic                     m_axis_tuser,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [COEF_W-1:0]   cfg_wdata_i
);

  // Stage numbering: registers count from the input transfer.
  localparam int T0  = 1 + NUM_W + 1;
  localparam int LAT = T0 + 23;
  localparam logic signed [QW-1:0] K3_64 =
    {{(QW-COEF_W){RADIAL_THREE_Q24[COEF_W-1]}}, RADIAL_THREE_Q24};

  // Configuration registers.
  logic [FOC_W-1:0]         fx_q, fy_q;
  logic signed [COORD_W-1:0] cx_q, cy_q;
  logic signed [COEF_W-1:0]  k1_q, k2_q, p1_q, p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= FOC_W'(256);
      fy_q <= FOC_W'(256);
      cx_q <= '0;
      cy_q <= '0;
      k1_q <= '0;
      k2_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_FOCAL_X:    fx_q <= cfg_wdata_i[FOC_W-1:0];
        REG_FOCAL_Y:    fy_q <= cfg_wdata_i[FOC_W-1:0];
        REG_CENTER_X:   cx_q <= cfg_wdata_i[COORD_W-1:0];
        REG_CENTER_Y:   cy_q <= cfg_wdata_i[COORD_W-1:0];
        REG_RADIAL_ONE: k1_q <= cfg_wdata_i;
        REG_RADIAL_TWO: k2_q <= cfg_wdata_i;
        REG_TANG_ONE:   p1_q <= cfg_wdata_i;
        REG_TANG_TWO:   p2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A focal length of zero is treated as the smallest step.
  logic [FOC_W-1:0] fx_eff, fy_eff;
  logic signed [QW-1:0] fx64, fy64, cx64, cy64, k1_64, k2_64, p1_64, p2_64;

  assign fx_eff = (fx_q == '0) ? FOC_W'(1) : fx_q;
  assign fy_eff = (fy_q == '0) ? FOC_W'(1) : fy_q;
  assign fx64   = signed'(QW'(fx_eff));
  assign fy64   = signed'(QW'(fy_eff));
  assign cx64   = {{(QW-COORD_W){cx_q[COORD_W-1]}}, cx_q};
  assign cy64   = {{(QW-COORD_W){cy_q[COORD_W-1]}}, cy_q};
  assign k1_64  = {{(QW-COEF_W){k1_q[COEF_W-1]}}, k1_q};
  assign k2_64  = {{(QW-COEF_W){k2_q[COEF_W-1]}}, k2_q};
  assign p1_64  = {{(QW-COEF_W){p1_q[COEF_W-1]}}, p1_q};
  assign p2_64  = {{(QW-COEF_W){p2_q[COEF_W-1]}}, p2_q};

  // Global advance: the whole pipeline steps whenever the output buffer has room.
  logic       en;
  logic       acc_w, push_w, pop_w;
  logic [1:0] ocnt_q;
  logic [LAT:1] vld_q;

  assign en            = (ocnt_q != 2'd2);
  assign s_axis_tready = en;
  assign acc_w         = s_axis_tvalid & en;
  assign push_w        = vld_q[LAT] & en;
  assign pop_w         = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-1:1], acc_w};
    end
  end

  // Stage 1: offsets from the principal point.
  logic signed [DIFF_W-1:0] dcol_q, drow_q;
  logic signed [COORD_W-1:0] in_col, in_row;

  assign in_col = s_axis_tdata[COORD_W-1:0];
  assign in_row = s_axis_tdata[2*COORD_W-1:COORD_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dcol_q <= {in_col[COORD_W-1], in_col} - {cx_q[COORD_W-1], cx_q};
      drow_q <= {in_row[COORD_W-1], in_row} - {cy_q[COORD_W-1], cy_q};
    end
  end

  // Normalized coordinates, available at T0.
  logic signed [QW-1:0] x_w, y_w;

  ldpm_div u_div_x (.clk_i, .en_i(en), .d_i(dcol_q), .f_i(fx_eff), .q_o(x_w));
  ldpm_div u_div_y (.clk_i, .en_i(en), .d_i(drow_q), .f_i(fy_eff), .q_o(y_w));

  // Squares and cross term, T0+3.
  logic signed [QW-1:0] xx_w, yy_w, xy_w;
  logic                 xx_s, yy_s, xy_s;

  ldpm_qmul u_xx (.clk_i, .en_i(en), .a_i(x_w), .b_i(x_w), .p_o(xx_w), .sat_o(xx_s));
  ldpm_qmul u_yy (.clk_i, .en_i(en), .a_i(y_w), .b_i(y_w), .p_o(yy_w), .sat_o(yy_s));
  ldpm_qmul u_xy (.clk_i, .en_i(en), .a_i(x_w), .b_i(y_w), .p_o(xy_w), .sat_o(xy_s));

  // r squared and doubled squares, T0+4; tangential sums, T0+5.
  sres_t rr_q, xx2_q, yy2_q, sx_q, sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rr_q  <= sadd(xx_w, yy_w);
      xx2_q <= sadd(xx_w, xx_w);
      yy2_q <= sadd(yy_w, yy_w);
      sx_q  <= sadd(rr_q.v, xx2_q.v);
      sy_q  <= sadd(rr_q.v, yy2_q.v);
    end
  end

  // Tangential cross products, T0+6, doubled at T0+7.
  logic signed [QW-1:0] p1xy_w, p2xy_w;
  logic                 p1xy_s, p2xy_s;
  sres_t                tx_q, ty_q;

  ldpm_qmul u_p1xy (.clk_i, .en_i(en), .a_i(p1_64), .b_i(xy_w), .p_o(p1xy_w),
                    .sat_o(p1xy_s));
  ldpm_qmul u_p2xy (.clk_i, .en_i(en), .a_i(p2_64), .b_i(xy_w), .p_o(p2xy_w),
                    .sat_o(p2xy_s));

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q <= sadd(p1xy_w, p1xy_w);
      ty_q <= sadd(p2xy_w, p2xy_w);
    end
  end

  // Tangential square terms, T0+8.
  logic signed [QW-1:0] p2s_w, p1s_w;
  logic                 p2s_s, p1s_s;

  ldpm_qmul u_p2s (.clk_i, .en_i(en), .a_i(p2_64), .b_i(sx_q.v), .p_o(p2s_w),
                   .sat_o(p2s_s));
  ldpm_qmul u_p1s (.clk_i, .en_i(en), .a_i(p1_64), .b_i(sy_q.v), .p_o(p1s_w),
                   .sat_o(p1s_s));

  // Radial powers, T0+7 and T0+10.
  logic signed [QW-1:0] r4_w, r6_w, rr_d, k1rr_w, k2r4_w, k3r6_w;
  logic                 r4_s, r6_s, k1rr_s, k2r4_s, k3r6_s;

  ldpm_qmul u_r4 (.clk_i, .en_i(en), .a_i(rr_q.v), .b_i(rr_q.v), .p_o(r4_w), .sat_o(r4_s));
  ldpm_dly #(.W(QW), .N(3)) u_rr_d (.clk_i, .en_i(en), .d_i(rr_q.v), .q_o(rr_d));
  ldpm_qmul u_r6 (.clk_i, .en_i(en), .a_i(r4_w), .b_i(rr_d), .p_o(r6_w), .sat_o(r6_s));

  ldpm_qmul u_k1 (.clk_i, .en_i(en), .a_i(k1_64), .b_i(rr_q.v), .p_o(k1rr_w),
                  .sat_o(k1rr_s));
  ldpm_qmul u_k2 (.clk_i, .en_i(en), .a_i(k2_64), .b_i(r4_w), .p_o(k2r4_w),
                  .sat_o(k2r4_s));
  ldpm_qmul u_k3 (.clk_i, .en_i(en), .a_i(K3_64), .b_i(r6_w), .p_o(k3r6_w),
                  .sat_o(k3r6_s));

  // Radial gain accumulated in model order: T0+8, T0+11, T0+14.
  sres_t                kr1_q, kr2_q, kr3_q;
  logic signed [QW-1:0] kr1_d, kr2_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      kr1_q <= sadd(ONE_Q24, k1rr_w);
      kr2_q <= sadd(kr1_d, k2r4_w);
      kr3_q <= sadd(kr2_d, k3r6_w);
    end
  end

  ldpm_dly #(.W(QW), .N(2)) u_kr1_d (.clk_i, .en_i(en), .d_i(kr1_q.v), .q_o(kr1_d));
  ldpm_dly #(.W(QW), .N(2)) u_kr2_d (.clk_i, .en_i(en), .d_i(kr2_q.v), .q_o(kr2_d));

  // Scaled coordinates, T0+17.
  logic signed [QW-1:0] x_d, y_d, dx0_w, dy0_w;
  logic                 dx0_s, dy0_s;

  ldpm_dly #(.W(QW), .N(14)) u_x_d (.clk_i, .en_i(en), .d_i(x_w), .q_o(x_d));
  ldpm_dly #(.W(QW), .N(14)) u_y_d (.clk_i, .en_i(en), .d_i(y_w), .q_o(y_d));

  ldpm_qmul u_dx0 (.clk_i, .en_i(en), .a_i(x_d), .b_i(kr3_q.v), .p_o(dx0_w),
                   .sat_o(dx0_s));
  ldpm_qmul u_dy0 (.clk_i, .en_i(en), .a_i(y_d), .b_i(kr3_q.v), .p_o(dy0_w),
                   .sat_o(dy0_s));

  // Tangential terms aligned to the scaled coordinates.
  logic signed [QW-1:0] tx_d, ty_d, p2s_d, p1s_d;

  ldpm_dly #(.W(QW), .N(10)) u_tx_d  (.clk_i, .en_i(en), .d_i(tx_q.v), .q_o(tx_d));
  ldpm_dly #(.W(QW), .N(11)) u_ty_d  (.clk_i, .en_i(en), .d_i(ty_q.v), .q_o(ty_d));
  ldpm_dly #(.W(QW), .N(10)) u_p2s_d (.clk_i, .en_i(en), .d_i(p2s_w), .q_o(p2s_d));
  ldpm_dly #(.W(QW), .N(9))  u_p1s_d (.clk_i, .en_i(en), .d_i(p1s_w), .q_o(p1s_d));

  // Distorted normalized coordinates, T0+18 and T0+19.
  sres_t dxa_q, dya_q, dxb_q, dyb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dxa_q <= sadd(dx0_w, tx_d);
      dya_q <= sadd(dy0_w, p1s_d);
      dxb_q <= sadd(dxa_q.v, p2s_d);
      dyb_q <= sadd(dya_q.v, ty_d);
    end
  end

  // Back to pixels, T0+22.
  logic signed [QW-1:0] ox0_w, oy0_w;
  logic                 ox0_s, oy0_s;

  ldpm_qmul u_ox (.clk_i, .en_i(en), .a_i(fx64), .b_i(dxb_q.v), .p_o(ox0_w), .sat_o(ox0_s));
  ldpm_qmul u_oy (.clk_i, .en_i(en), .a_i(fy64), .b_i(dyb_q.v), .p_o(oy0_w), .sat_o(oy0_s));

  // Final stage: add the principal point, then clamp to the coordinate range.
  sres_t                sox, soy;
  logic signed [COORD_W-1:0] oc_d, or_d;
  logic                 osat_d;
  logic signed [COORD_W-1:0] oc_q, or_q;
  logic                 osat_q;

  always_comb begin
    sox    = sadd(ox0_w, cx64);
    soy    = sadd(oy0_w, cy64);
    osat_d = sox.sat | soy.sat;
    if (sox.v > OUT_MAX) begin
      oc_d   = OUT_MAX[COORD_W-1:0];
      osat_d = 1'b1;
    end else if (sox.v < OUT_MIN) begin
      oc_d   = OUT_MIN[COORD_W-1:0];
      osat_d = 1'b1;
    end else begin
      oc_d   = sox.v[COORD_W-1:0];
    end
    if (soy.v > OUT_MAX) begin
      or_d   = OUT_MAX[COORD_W-1:0];
      osat_d = 1'b1;
    end else if (soy.v < OUT_MIN) begin
      or_d   = OUT_MIN[COORD_W-1:0];
      osat_d = 1'b1;
    end else begin
      or_d   = soy.v[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oc_q   <= oc_d;
      or_q   <= or_d;
      osat_q <= osat_d;
    end
  end

  // Saturation flags, indexed by the stage whose registers hold them. A sticky chain
  // carries their OR along with the point.
  logic [LAT:T0]   flag_w;
  logic [LAT:T0+1] sat_q;

  always_comb begin
    flag_w         = '0;
    flag_w[T0+3]   = xx_s | yy_s | xy_s;
    flag_w[T0+4]   = rr_q.sat | xx2_q.sat | yy2_q.sat;
    flag_w[T0+5]   = sx_q.sat | sy_q.sat;
    flag_w[T0+6]   = p1xy_s | p2xy_s;
    flag_w[T0+7]   = r4_s | k1rr_s | tx_q.sat | ty_q.sat;
    flag_w[T0+8]   = p2s_s | p1s_s | kr1_q.sat;
    flag_w[T0+10]  = r6_s | k2r4_s;
    flag_w[T0+11]  = kr2_q.sat;
    flag_w[T0+13]  = k3r6_s;
    flag_w[T0+14]  = kr3_q.sat;
    flag_w[T0+17]  = dx0_s | dy0_s;
    flag_w[T0+18]  = dxa_q.sat | dya_q.sat;
    flag_w[T0+19]  = dxb_q.sat | dyb_q.sat;
    flag_w[T0+22]  = ox0_s | oy0_s;
    flag_w[LAT]    = osat_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_q[T0+1] <= flag_w[T0];
      for (int t = T0 + 2; t <= LAT; t++) begin
        sat_q[t] <= sat_q[t-1] | flag_w[t-1];
      end
    end
  end

  // Two-entry output buffer: one waiting result does not stop the pipeline.
  res_t ent_q [2];
  logic wr_q, rd_q;
  res_t res_w;

  assign res_w.col  = oc_q;
  assign res_w.row  = or_q;
  assign res_w.clip = sat_q[LAT] | flag_w[LAT];

  always_ff @(posedge clk_i) begin
    if (push_w) begin
      ent_q[wr_q] <= res_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
    end else begin
      if (push_w) begin
        wr_q <= ~wr_q;
      end
      if (pop_w) begin
        rd_q <= ~rd_q;
      end
      if (push_w && !pop_w) begin
        ocnt_q <= ocnt_q + 2'd1;
      end else if (pop_w && !push_w) begin
        ocnt_q <= ocnt_q - 2'd1;
      end
    end
  end

  assign m_axis_tvalid = (ocnt_q != 2'd0);
  assign m_axis_tdata  = {ent_q[rd_q].row, ent_q[rd_q].col};
  assign m_axis_tuser  = ent_q[rd_q].clip;

  // A result in the last stage is never dropped while the pipeline is frozen.
  `LDPM_ASSERT_NEXT(a_stall_keeps_result, vld_q[LAT] && !en, vld_q[LAT], "result lost in stall")
  // Input is refused only when the output buffer is full.
  `LDPM_ASSERT_NOW(a_ready_full, !s_axis_tready, ocnt_q == 2'd2, "ready low with buffer room")
  // A transfer into the buffer without one out grows the count by one.
  `LDPM_ASSERT_NEXT(a_cnt_grow, push_w && !pop_w, ocnt_q == $past(ocnt_q) + 2'd1, "count slip")

endmodule
`default_nettype wire
